### design/snms_pkg.sv
// ---------------------------------------------------------------------------
// snms_pkg: shared types and constants for the scored top-N match selector
// Widths, scoring constants, register indexes, command and result words.
// ---------------------------------------------------------------------------
package snms_pkg;

  localparam int TOP_N      = 16;
  localparam int CNT_W      = $clog2(TOP_N + 1);
  localparam int IDX_W      = (TOP_N > 1) ? $clog2(TOP_N) : 1;

  localparam int HASH_W     = 32;
  localparam int BANK_W     = 8;
  localparam int ADDR_W     = 16;
  localparam int CONF_W     = 7;
  localparam int LIMIT_W    = 5;
  localparam int OUTCNT_W   = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CONF_W-1:0] CONF_EXACT     = CONF_W'(100);
  localparam logic [CONF_W-1:0] CONF_STRUCT    = CONF_W'(60);
  localparam logic [CONF_W-1:0] CONF_BONUS     = CONF_W'(5);
  localparam logic [CONF_W-1:0] CONF_BONUS_CAP = CONF_W'(95);
  localparam logic [CONF_W-1:0] CONF_CALLEE    = CONF_W'(40);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(16);

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  localparam int OQ_DEPTH   = 2;
  localparam int OQ_AW      = $clog2(OQ_DEPTH);
  localparam int OQ_CW      = $clog2(OQ_DEPTH + 1);

  typedef enum logic {
    OP_OFFER = 1'b0,
    OP_READ  = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_VALID     = 3'd0,
    REG_REF_STRUCTURE = 3'd1,
    REG_REF_OPERAND   = 3'd2,
    REG_REF_CALLEE    = 3'd3,
    REG_REF_BANK      = 3'd4,
    REG_REF_ADDRESS   = 3'd5,
    REG_LIST_LIMIT    = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_t;

  typedef struct packed {
    logic               exact;
    logic [CONF_W-1:0]  conf;
    logic [ADDR_W-1:0]  addr;
    logic [BANK_W-1:0]  bank;
  } entry_t;

  typedef struct packed {
    opcode_t op;
    entry_t  entry;
  } cmd_t;

  typedef struct packed {
    logic                valid;
    entry_t              entry;
    logic [OUTCNT_W-1:0] count;
    logic                last;
  } out_word_t;

endpackage

### design/snms_cmd_fifo.sv
// ---------------------------------------------------------------------------
// snms_cmd_fifo: command queue between the scoring front and the list back
// A small flop-based queue of classified words; the head is visible directly.
// ---------------------------------------------------------------------------
module snms_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  snms_pkg::cmd_t push_word,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output snms_pkg::cmd_t head
);
  import snms_pkg::*;

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wp_r, wp_nxt;
  logic [CMDQ_AW-1:0] rp_r, rp_nxt;
  logic [CMDQ_CW-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_word;
    end
  end

endmodule

### design/snms_front.sv
// ---------------------------------------------------------------------------
// snms_front: reference registers and candidate scoring
// Holds the configuration, scores each offered candidate and forwards scored
// offers and read-out requests as command words; unscored offers are dropped.
// ---------------------------------------------------------------------------
module snms_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [snms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [snms_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_push,
  input  logic                               in_opcode,
  input  logic [snms_pkg::HASH_W-1:0]        in_cand_structure_hash,
  input  logic [snms_pkg::HASH_W-1:0]        in_cand_operand_hash,
  input  logic [snms_pkg::HASH_W-1:0]        in_cand_callee_hash,
  input  logic [snms_pkg::BANK_W-1:0]        in_cand_bank,
  input  logic [snms_pkg::ADDR_W-1:0]        in_cand_address,
  input  logic                               q_full,
  output logic                               q_push,
  output snms_pkg::cmd_t                     q_word,
  output logic [snms_pkg::CNT_W-1:0]         limit
);
  import snms_pkg::*;

  logic                ref_valid_r;
  logic [HASH_W-1:0]   ref_structure_r;
  logic [HASH_W-1:0]   ref_operand_r;
  logic [HASH_W-1:0]   ref_callee_r;
  logic [BANK_W-1:0]   ref_bank_r;
  logic [ADDR_W-1:0]   ref_address_r;
  logic [LIMIT_W-1:0]  list_limit_r;

  logic                struct_eq, operand_eq, callee_hit, loc_eq, scored;
  logic [CONF_W-1:0]   base_conf, conf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_valid_r     <= 1'b0;
      ref_structure_r <= '0;
      ref_operand_r   <= '0;
      ref_callee_r    <= '0;
      ref_bank_r      <= '0;
      ref_address_r   <= '0;
      list_limit_r    <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REF_VALID:     ref_valid_r     <= cfg_wdata[0];
        REG_REF_STRUCTURE: ref_structure_r <= cfg_wdata[HASH_W-1:0];
        REG_REF_OPERAND:   ref_operand_r   <= cfg_wdata[HASH_W-1:0];
        REG_REF_CALLEE:    ref_callee_r    <= cfg_wdata[HASH_W-1:0];
        REG_REF_BANK:      ref_bank_r      <= cfg_wdata[BANK_W-1:0];
        REG_REF_ADDRESS:   ref_address_r   <= cfg_wdata[ADDR_W-1:0];
        REG_LIST_LIMIT:    list_limit_r    <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // The programmed limit saturates at the list depth.
  always_comb begin
    if (32'(list_limit_r) > 32'(TOP_N)) begin
      limit = CNT_W'(TOP_N);
    end else begin
      limit = CNT_W'(list_limit_r);
    end
  end

  always_comb begin
    struct_eq  = (in_cand_structure_hash == ref_structure_r);
    operand_eq = (in_cand_operand_hash == ref_operand_r);
    callee_hit = (ref_callee_r != '0) && (in_cand_callee_hash == ref_callee_r);
    loc_eq     = (in_cand_bank == ref_bank_r) && (in_cand_address == ref_address_r);
    base_conf  = operand_eq ? CONF_EXACT : CONF_STRUCT;
    if (struct_eq) begin
      conf = (loc_eq && (base_conf < CONF_BONUS_CAP)) ? base_conf + CONF_BONUS : base_conf;
    end else begin
      conf = CONF_CALLEE;
    end
    scored = ref_valid_r && (struct_eq || callee_hit);
  end

  always_comb begin
    q_word.op          = opcode_t'(in_opcode);
    q_word.entry.exact = struct_eq && operand_eq;
    q_word.entry.conf  = conf;
    q_word.entry.addr  = in_cand_address;
    q_word.entry.bank  = in_cand_bank;
    q_push = in_push && !q_full && ((opcode_t'(in_opcode) == OP_READ) || scored);
  end

endmodule

### design/snms_back.sv
// ---------------------------------------------------------------------------
// snms_back: best-list insertion chain and read-out sequencer
// A row of entry cells kept in descending score order; an offer is inserted
// by compare and shift, a read-out walks the held entries.
// ---------------------------------------------------------------------------
module snms_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [snms_pkg::CNT_W-1:0]  limit,
  input  logic                        cmd_empty,
  input  snms_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output snms_pkg::out_word_t         out_word
);
  import snms_pkg::*;

  back_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   held_r, held_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  entry_t             cells_r [TOP_N];

  logic [CNT_W-1:0]   held_eff, limit_m1, held_m1;
  logic [TOP_N-1:0]   lt;
  logic               limit_zero, has_room, ins_ok, ins_en, rd_last;

  out_word_t          oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0]   oq_wp_r, oq_rp_r;
  logic [OQ_CW-1:0]   oq_cnt_r;
  logic               oq_push, oq_pop, oq_space;
  out_word_t          oq_word;

  // Entries past a lowered limit are cut before the new offer is placed.
  always_comb begin
    held_eff   = (held_r > limit) ? limit : held_r;
    limit_zero = (limit == '0);
    limit_m1   = limit - 1'b1;
    held_m1    = held_r - 1'b1;
    has_room   = (held_eff < limit);
    for (int i = 0; i < TOP_N; i++) begin
      lt[i] = !(CNT_W'(i) < held_eff) || (cells_r[i].conf < cmd.entry.conf);
    end
    ins_ok  = !limit_zero && (has_room || lt[limit_m1[IDX_W-1:0]]);
    rd_last = (rd_idx_r == held_m1[IDX_W-1:0]);
  end

  assign oq_space  = (oq_cnt_r != OQ_CW'(OQ_DEPTH));
  assign out_empty = (oq_cnt_r == '0);
  assign out_word  = oq_r[oq_rp_r];
  assign oq_pop    = out_pop && !out_empty;

  always_comb begin
    state_nxt  = state_r;
    held_nxt   = held_r;
    rd_idx_nxt = rd_idx_r;
    cmd_pop    = 1'b0;
    oq_push    = 1'b0;
    oq_word    = '0;
    ins_en     = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) begin
          if (cmd.op == OP_READ) begin
            if (held_r == '0) begin
              if (oq_space) begin
                oq_push      = 1'b1;
                oq_word.last = 1'b1;
                cmd_pop      = 1'b1;
              end
            end else begin
              state_nxt  = BK_READ;
              rd_idx_nxt = '0;
              cmd_pop    = 1'b1;
            end
          end else begin
            cmd_pop = 1'b1;
            ins_en  = ins_ok;
            if (limit_zero) begin
              held_nxt = '0;
            end else if (ins_ok && has_room) begin
              held_nxt = held_eff + 1'b1;
            end else begin
              held_nxt = held_eff;
            end
          end
        end
      end
      BK_READ: begin
        if (oq_space) begin
          oq_push       = 1'b1;
          oq_word.valid = 1'b1;
          oq_word.entry = cells_r[rd_idx_r];
          oq_word.count = OUTCNT_W'(held_r);
          oq_word.last  = rd_last;
          if (rd_last) begin
            held_nxt  = '0;
            state_nxt = BK_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      held_r   <= '0;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  // Each cell keeps its entry, takes the new one at the first lower score,
  // or takes its upper neighbor's entry below that point.
  always_ff @(posedge clk) begin
    if (ins_en) begin
      if (lt[0]) begin
        cells_r[0] <= cmd.entry;
      end
      for (int i = 1; i < TOP_N; i++) begin
        if (lt[i]) begin
          if (!lt[i-1]) begin
            cells_r[i] <= cmd.entry;
          end else begin
            cells_r[i] <= cells_r[i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wp_r <= oq_wp_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rp_r <= oq_rp_r + 1'b1;
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (oq_pop && !oq_push) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wp_r] <= oq_word;
    end
  end

  a_held_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(TOP_N))
    else $error("held count exceeds list depth");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_READ |-> held_r != '0)
    else $error("read-out walking an empty list");

  a_read_ends_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_READ && oq_push && oq_word.last) |=> (state_r == BK_IDLE && held_r == '0))
    else $error("list not cleared after final read-out word");

  a_no_cmd_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_READ |-> !cmd_pop)
    else $error("command taken during read-out");

endmodule

### design/scored_top_n_match_selector.sv
// ---------------------------------------------------------------------------
// scored_top_n_match_selector: top level of the scored top-N match selector
// Scores candidate fingerprints against a reference and keeps the best N.
// ---------------------------------------------------------------------------
// The front scores a candidate in the cycle it is accepted and queues it for
// the list; candidates that match nothing never reach the queue. The back
// inserts one queued offer per cycle through a compare-and-shift row of
// TOP_N cells, so offers sustain one per cycle while no read-out is busy. A
// read-out of a non-empty list enters the read state, then gives one word per
// held entry through the single read port of the cell row as output space
// allows; an empty list gives its single word. Offers queued behind a read-out
// wait in the four-word command queue, and in_full rises once that queue is
// full. Results drain through a two-word output queue.
module scored_top_n_match_selector (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [snms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [snms_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic                             in_opcode,
  input  logic [snms_pkg::HASH_W-1:0]      in_cand_structure_hash,
  input  logic [snms_pkg::HASH_W-1:0]      in_cand_operand_hash,
  input  logic [snms_pkg::HASH_W-1:0]      in_cand_callee_hash,
  input  logic [snms_pkg::BANK_W-1:0]      in_cand_bank,
  input  logic [snms_pkg::ADDR_W-1:0]      in_cand_address,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic                             out_entry_valid,
  output logic [snms_pkg::BANK_W-1:0]      out_entry_bank,
  output logic [snms_pkg::ADDR_W-1:0]      out_entry_address,
  output logic [snms_pkg::CONF_W-1:0]      out_entry_confidence,
  output logic                             out_entry_exact,
  output logic [snms_pkg::OUTCNT_W-1:0]    out_list_count,
  output logic                             out_last
);
  import snms_pkg::*;

  logic             q_push, q_full, q_pop, q_empty;
  cmd_t             q_word, q_head;
  logic [CNT_W-1:0] limit;
  out_word_t        res;

  assign in_full = q_full;

  snms_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_push                (in_push),
    .in_opcode              (in_opcode),
    .in_cand_structure_hash (in_cand_structure_hash),
    .in_cand_operand_hash   (in_cand_operand_hash),
    .in_cand_callee_hash    (in_cand_callee_hash),
    .in_cand_bank           (in_cand_bank),
    .in_cand_address        (in_cand_address),
    .q_full                 (q_full),
    .q_push                 (q_push),
    .q_word                 (q_word),
    .limit                  (limit)
  );

  snms_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_word),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  snms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .limit     (limit),
    .cmd_empty (q_empty),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (res)
  );

  assign out_entry_valid      = res.valid;
  assign out_entry_bank       = res.entry.bank;
  assign out_entry_address    = res.entry.addr;
  assign out_entry_confidence = res.entry.conf;
  assign out_entry_exact      = res.entry.exact;
  assign out_list_count       = res.count;
  assign out_last             = res.last;

endmodule

### tb/snms_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// snms_checker: result checker for the scored top-N match selector
// Watches the configuration port and both queue channels, keeps its own
// scored best list, and compares every popped result word with the oldest
// predicted word.
// ---------------------------------------------------------------------------
module snms_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [snms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [snms_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_push,
  input  logic                            in_full,
  input  logic                            in_opcode,
  input  logic [snms_pkg::HASH_W-1:0]     in_cand_structure_hash,
  input  logic [snms_pkg::HASH_W-1:0]     in_cand_operand_hash,
  input  logic [snms_pkg::HASH_W-1:0]     in_cand_callee_hash,
  input  logic [snms_pkg::BANK_W-1:0]     in_cand_bank,
  input  logic [snms_pkg::ADDR_W-1:0]     in_cand_address,
  input  logic                            out_empty,
  input  logic                            out_pop,
  input  logic                            out_entry_valid,
  input  logic [snms_pkg::BANK_W-1:0]     out_entry_bank,
  input  logic [snms_pkg::ADDR_W-1:0]     out_entry_address,
  input  logic [snms_pkg::CONF_W-1:0]     out_entry_confidence,
  input  logic                            out_entry_exact,
  input  logic [snms_pkg::OUTCNT_W-1:0]   out_list_count,
  input  logic                            out_last,
  output int                              errors,
  output int                              pending,
  output int                              checked
);
  import snms_pkg::*;

  // Predicted copy of the block state and its reference registers.
  entry_t              ranked [TOP_N];
  int                  held;
  logic                ref_present;
  logic [HASH_W-1:0]   ref_structure;
  logic [HASH_W-1:0]   ref_operand;
  logic [HASH_W-1:0]   ref_callee;
  logic [BANK_W-1:0]   ref_bank;
  logic [ADDR_W-1:0]   ref_address;
  logic [LIMIT_W-1:0]  keep_limit;

  out_word_t expected_words [$];
  int        err_count;
  int        reported;
  int        pop_count;

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  task automatic clear_prediction();
    held          = 0;
    ref_present   = 1'b0;
    ref_structure = '0;
    ref_operand   = '0;
    ref_callee    = '0;
    ref_bank      = '0;
    ref_address   = '0;
    keep_limit    = LIMIT_RESET;
    expected_words.delete();
    for (int i = 0; i < TOP_N; i++) ranked[i] = '0;
  endtask

  task automatic score_offer(input logic [HASH_W-1:0] sh, input logic [HASH_W-1:0] oh,
                             input logic [HASH_W-1:0] ch, input logic [BANK_W-1:0] bk,
                             input logic [ADDR_W-1:0] ad);
    logic [CONF_W-1:0] conf;
    logic              exact;
    int                lim;
    int                pos;
    exact = 1'b0;
    if (!ref_present) return;
    if (sh == ref_structure) begin
      if (oh == ref_operand) begin
        conf  = CONF_EXACT;
        exact = 1'b1;
      end else begin
        conf = CONF_STRUCT;
      end
      if (bk == ref_bank && ad == ref_address && conf < CONF_BONUS_CAP) conf = conf + CONF_BONUS;
    end else if (ref_callee != '0 && ch == ref_callee) begin
      conf = CONF_CALLEE;
    end else begin
      return;
    end

    lim = (int'(keep_limit) > TOP_N) ? TOP_N : int'(keep_limit);
    // A lowered limit trims the list before the candidate is placed.
    if (held > lim) held = lim;
    if (lim == 0) return;

    if (held < lim) begin
      pos  = held;
      held = held + 1;
    end else if (conf > ranked[lim-1].conf) begin
      pos = lim - 1;
    end else begin
      return;
    end
    // Equal scores stay ahead of the newcomer, so the list is stable.
    while (pos > 0 && ranked[pos-1].conf < conf) begin
      ranked[pos] = ranked[pos-1];
      pos--;
    end
    ranked[pos].exact = exact;
    ranked[pos].conf  = conf;
    ranked[pos].addr  = ad;
    ranked[pos].bank  = bk;
  endtask

  task automatic emit_list();
    out_word_t w;
    int        n;
    n = (held > TOP_N) ? TOP_N : held;
    if (n == 0) begin
      w       = '0;
      w.last  = 1'b1;
      expected_words.push_back(w);
    end else begin
      for (int k = 0; k < n; k++) begin
        w.valid = 1'b1;
        w.entry = ranked[k];
        w.count = OUTCNT_W'(n);
        w.last  = (k == n - 1);
        expected_words.push_back(w);
      end
    end
    held = 0;
  endtask

  task automatic compare_word();
    out_word_t w;
    if (expected_words.size() == 0) begin
      err_count++;
      if (reported < 10) begin
        reported++;
        $display("%0t: result word with nothing expected: valid=%0b bank=%0h addr=%0h",
                 $realtime, out_entry_valid, out_entry_bank, out_entry_address);
      end
      return;
    end
    w = expected_words.pop_front();
    pop_count++;
    if (out_entry_valid !== w.valid || out_entry_bank !== w.entry.bank ||
        out_entry_address !== w.entry.addr || out_entry_confidence !== w.entry.conf ||
        out_entry_exact !== w.entry.exact || out_list_count !== w.count ||
        out_last !== w.last) begin
      err_count++;
      if (reported < 10) begin
        reported++;
        $display("%0t: mismatch, expected valid=%0b bank=%0h addr=%0h conf=%0d exact=%0b cnt=%0d last=%0b",
                 $realtime, w.valid, w.entry.bank, w.entry.addr, w.entry.conf, w.entry.exact,
                 w.count, w.last);
        $display("%0t:             got valid=%0b bank=%0h addr=%0h conf=%0d exact=%0b cnt=%0d last=%0b",
                 $realtime, out_entry_valid, out_entry_bank, out_entry_address,
                 out_entry_confidence, out_entry_exact, out_list_count, out_last);
      end
    end
  endtask

  initial begin
    err_count = 0;
    reported  = 0;
    pop_count = 0;
    clear_prediction();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_prediction();
    end else begin
      // Outputs first, so a read-out taken at this edge cannot match a word
      // popped at the same edge.
      if (out_pop && !out_empty) compare_word();

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_REF_VALID:     ref_present   = cfg_wdata[0];
          REG_REF_STRUCTURE: ref_structure = cfg_wdata[HASH_W-1:0];
          REG_REF_OPERAND:   ref_operand   = cfg_wdata[HASH_W-1:0];
          REG_REF_CALLEE:    ref_callee    = cfg_wdata[HASH_W-1:0];
          REG_REF_BANK:      ref_bank      = cfg_wdata[BANK_W-1:0];
          REG_REF_ADDRESS:   ref_address   = cfg_wdata[ADDR_W-1:0];
          REG_LIST_LIMIT:    keep_limit    = cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (in_push && !in_full) begin
        if (in_opcode == OP_READ) emit_list();
        else score_offer(in_cand_structure_hash, in_cand_operand_hash, in_cand_callee_hash,
                         in_cand_bank, in_cand_address);
      end
    end
    errors  <= err_count;
    pending <= expected_words.size();
    checked <= pop_count;
  end

endmodule

### tb/scored_top_n_match_selector_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// scored_top_n_match_selector_tb: testbench top for the match selector
// Programs reference fingerprints, streams directed and random candidate
// and read-out words with random stalls on both queues, and reports the
// verdict from the checker's mismatch and pending counts.
// ---------------------------------------------------------------------------
module scored_top_n_match_selector_tb;
  import snms_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 410;

  typedef struct {
    logic               valid;
    logic [HASH_W-1:0]  sh;
    logic [HASH_W-1:0]  oh;
    logic [HASH_W-1:0]  ch;
    logic [BANK_W-1:0]  bank;
    logic [ADDR_W-1:0]  addr;
    logic [LIMIT_W-1:0] limit;
  } fingerprint_cfg_t;

  typedef enum int {CAND_EXACT, CAND_STRUCT, CAND_CALLEE, CAND_NOISE} cand_kind_t;
  typedef enum int {AT_HOME, BANK_OFF, ADDR_OFF, ANYWHERE} cand_place_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic                  in_opcode = 1'b0;
  logic [HASH_W-1:0]     in_cand_structure_hash = '0;
  logic [HASH_W-1:0]     in_cand_operand_hash = '0;
  logic [HASH_W-1:0]     in_cand_callee_hash = '0;
  logic [BANK_W-1:0]     in_cand_bank = '0;
  logic [ADDR_W-1:0]     in_cand_address = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic                  out_entry_valid;
  logic [BANK_W-1:0]     out_entry_bank;
  logic [ADDR_W-1:0]     out_entry_address;
  logic [CONF_W-1:0]     out_entry_confidence;
  logic                  out_entry_exact;
  logic [OUTCNT_W-1:0]   out_list_count;
  logic                  out_last;

  int   errors;
  int   pending;
  int   checked;
  logic calm = 1'b0;

  fingerprint_cfg_t cur;
  int               n_offers;
  int               n_reads;
  int               n_settings;

  always #5 clk = ~clk;

  scored_top_n_match_selector dut (.*);

  snms_checker u_checker (.*);

  // Result side: random stall bursts, none once the run is calm.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (calm) begin
      out_pop <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_pop <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  function automatic logic [HASH_W-1:0] pick_hash();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [HASH_W-1:0] flip_mask();
    return $urandom | (32'h1 << $urandom_range(0, 31));
  endfunction

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic program_reference(input fingerprint_cfg_t s);
    write_reg(REG_REF_VALID, CFG_DATA_W'(s.valid));
    write_reg(REG_REF_STRUCTURE, s.sh);
    write_reg(REG_REF_OPERAND, s.oh);
    write_reg(REG_REF_CALLEE, s.ch);
    write_reg(REG_REF_BANK, CFG_DATA_W'(s.bank));
    write_reg(REG_REF_ADDRESS, CFG_DATA_W'(s.addr));
    write_reg(REG_LIST_LIMIT, CFG_DATA_W'(s.limit));
    cfg_we <= 1'b0;
    cur = s;
    n_settings++;
  endtask

  // Holds push high from word to word; it only drops for an idle burst.
  task automatic push_word(input opcode_t op, input logic [HASH_W-1:0] sh,
                           input logic [HASH_W-1:0] oh, input logic [HASH_W-1:0] ch,
                           input logic [BANK_W-1:0] bk, input logic [ADDR_W-1:0] ad);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push                <= 1'b1;
    in_opcode              <= op;
    in_cand_structure_hash <= sh;
    in_cand_operand_hash   <= oh;
    in_cand_callee_hash    <= ch;
    in_cand_bank           <= bk;
    in_cand_address        <= ad;
    do @(posedge clk); while (in_full);
    if (op == OP_READ) n_reads++;
    else n_offers++;
  endtask

  task automatic read_list();
    push_word(OP_READ, $urandom, $urandom, $urandom, BANK_W'($urandom), ADDR_W'($urandom));
  endtask

  task automatic offer_candidate(input cand_kind_t kind, input cand_place_t place);
    logic [HASH_W-1:0] sh;
    logic [HASH_W-1:0] oh;
    logic [HASH_W-1:0] ch;
    logic [BANK_W-1:0] bk;
    logic [ADDR_W-1:0] ad;
    sh = $urandom;
    oh = $urandom;
    ch = $urandom;
    bk = BANK_W'($urandom);
    ad = ADDR_W'($urandom);
    case (kind)
      CAND_EXACT: begin
        sh = cur.sh;
        oh = cur.oh;
      end
      CAND_STRUCT: begin
        sh = cur.sh;
        oh = cur.oh ^ flip_mask();
      end
      CAND_CALLEE: begin
        sh = cur.sh ^ flip_mask();
        ch = cur.ch;
      end
      default: ;
    endcase
    case (place)
      AT_HOME: begin
        bk = cur.bank;
        ad = cur.addr;
      end
      BANK_OFF: begin
        bk = cur.bank ^ (8'h1 << $urandom_range(0, 7));
        ad = cur.addr;
      end
      ADDR_OFF: begin
        bk = cur.bank;
        ad = cur.addr ^ (16'h1 << $urandom_range(0, 15));
      end
      default: ;
    endcase
    push_word(OP_OFFER, sh, oh, ch, bk, ad);
  endtask

  // Lets every predicted word arrive and the offer queue run dry. The first
  // edge lets the checker count a word accepted at the edge just passed.
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_setting();
    fingerprint_cfg_t s;
    s.valid = ($urandom_range(0, 9) != 0);
    s.sh    = pick_hash();
    s.oh    = pick_hash();
    s.ch    = ($urandom_range(0, 4) == 0) ? '0 : pick_hash();
    s.bank  = BANK_W'($urandom);
    s.addr  = ADDR_W'($urandom);
    case ($urandom_range(0, 11))
      0:       s.limit = 5'd0;
      1:       s.limit = 5'd1;
      2:       s.limit = 5'd2;
      3:       s.limit = 5'd3;
      4:       s.limit = 5'd17;
      5:       s.limit = 5'd31;
      6, 7:    s.limit = 5'd16;
      default: s.limit = LIMIT_W'($urandom_range(1, 31));
    endcase
    program_reference(s);
  endtask

  task automatic random_word();
    cand_kind_t  kind;
    cand_place_t place;
    if ($urandom_range(0, 9) == 0) begin
      read_list();
      return;
    end
    case ($urandom_range(0, 19))
      0, 1, 2:             kind = CAND_EXACT;
      3, 4, 5, 6, 7, 8, 9: kind = CAND_STRUCT;
      10, 11, 12, 13, 14:  kind = CAND_CALLEE;
      default:             kind = CAND_NOISE;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: place = AT_HOME;
      4, 5:       place = BANK_OFF;
      6:          place = ADDR_OFF;
      default:    place = ANYWHERE;
    endcase
    offer_candidate(kind, place);
  endtask

  initial begin
    fingerprint_cfg_t s;
    int               counted;
    int               phase_len;
    n_offers   = 0;
    n_reads    = 0;
    n_settings = 0;
    counted    = 0;
    cur.valid  = 1'b0;
    cur.sh     = '0;
    cur.oh     = '0;
    cur.ch     = '0;
    cur.bank   = '0;
    cur.addr   = '0;
    cur.limit  = LIMIT_RESET;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset no reference is present: the offer is ignored.
    offer_candidate(CAND_EXACT, AT_HOME);
    read_list();
    settle();

    s.valid = 1'b1;
    s.sh    = $urandom;
    s.oh    = $urandom;
    s.ch    = flip_mask();
    s.bank  = BANK_W'($urandom);
    s.addr  = ADDR_W'($urandom);
    s.limit = 5'd16;
    program_reference(s);
    offer_candidate(CAND_STRUCT, BANK_OFF);
    offer_candidate(CAND_EXACT, AT_HOME);
    offer_candidate(CAND_STRUCT, AT_HOME);
    offer_candidate(CAND_CALLEE, ANYWHERE);
    offer_candidate(CAND_STRUCT, ADDR_OFF);
    offer_candidate(CAND_NOISE, ANYWHERE);
    offer_candidate(CAND_STRUCT, ANYWHERE);
    read_list();
    read_list();
    settle();

    // Extreme reference, no callee, a single slot.
    s.sh    = '1;
    s.oh    = '0;
    s.ch    = '0;
    s.bank  = '1;
    s.addr  = '1;
    s.limit = 5'd1;
    program_reference(s);
    push_word(OP_OFFER, '0, '0, '0, '0, '0);
    offer_candidate(CAND_STRUCT, ANYWHERE);
    offer_candidate(CAND_STRUCT, BANK_OFF);
    push_word(OP_OFFER, '1, '1, '1, '1, '1);
    offer_candidate(CAND_EXACT, ANYWHERE);
    read_list();
    settle();

    // A limit of zero keeps nothing.
    s.sh    = '0;
    s.oh    = '1;
    s.ch    = '1;
    s.bank  = '0;
    s.addr  = '0;
    s.limit = 5'd0;
    program_reference(s);
    push_word(OP_OFFER, '0, '0, '0, '0, '0);
    offer_candidate(CAND_CALLEE, AT_HOME);
    read_list();
    settle();

    // Fill above the next limit, then lower it and offer once more.
    s.sh    = $urandom;
    s.oh    = $urandom;
    s.ch    = flip_mask();
    s.limit = 5'd31;
    program_reference(s);
    offer_candidate(CAND_CALLEE, ANYWHERE);
    offer_candidate(CAND_STRUCT, ANYWHERE);
    offer_candidate(CAND_EXACT, BANK_OFF);
    offer_candidate(CAND_CALLEE, ANYWHERE);
    settle();
    s.limit = 5'd2;
    program_reference(s);
    offer_candidate(CAND_CALLEE, ANYWHERE);
    read_list();
    settle();

    while (counted < RANDOM_ITEMS) begin
      random_setting();
      phase_len = cur.valid ? $urandom_range(15, 50) : $urandom_range(3, 8);
      for (int i = 0; i < phase_len && counted < RANDOM_ITEMS; i++) begin
        random_word();
        if (cur.valid || in_opcode == OP_READ) counted++;
        if (counted >= RANDOM_ITEMS * 7 / 8) calm <= 1'b1;
      end
      if ($urandom_range(0, 1) == 0) read_list();
      settle();
    end
    read_list();
    settle();

    $display("Ran %0d candidate offers and %0d read-outs under %0d reference settings.",
             n_offers, n_reads, n_settings);
    $display("Checked %0d result words, %0d mismatching.", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
design/snms_pkg.sv
design/snms_cmd_fifo.sv
design/snms_front.sv
design/snms_back.sv
design/scored_top_n_match_selector.sv
tb/snms_checker.sv
tb/scored_top_n_match_selector_tb.sv
